// ===== hw/rtl/skn_pkg.sv =====
package skn_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int NUM_AXES       = 6;
    localparam int MEAS_W         = 32;
    localparam int EST_W          = 32;
    localparam int VAR_W          = 32;
    localparam int GAIN_FRAC      = 24;
    localparam int NORM_FRAC      = 16;
    localparam int SCALE_FRAC     = 32;
    localparam int LAM_W          = 17;
    localparam int REF_W          = 31;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 4;

    localparam logic [LAM_W-1:0] LAM_ONE = 17'h10000;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_Q_ACCEL     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R_ACCEL     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Q_MAGNET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R_MAGNET    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P_INITIAL   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_WEIGHT = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_REF = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_REF   = 4'd7;

    localparam logic [VAR_W-1:0] RST_NOISE     = 32'd16777;
    localparam logic [VAR_W-1:0] RST_P_INITIAL = 32'd16777216;
    localparam logic [LAM_W-1:0] RST_WEIGHT    = 17'd0;
    localparam logic [REF_W-1:0] RST_REF       = 31'd65536;

    typedef struct packed {
        logic signed [MEAS_W-1:0] meas_ax;
        logic signed [MEAS_W-1:0] meas_ay;
        logic signed [MEAS_W-1:0] meas_az;
        logic signed [MEAS_W-1:0] meas_mx;
        logic signed [MEAS_W-1:0] meas_my;
        logic signed [MEAS_W-1:0] meas_mz;
    } meas_t;

    typedef struct packed {
        logic signed [EST_W-1:0] est_ax;
        logic signed [EST_W-1:0] est_ay;
        logic signed [EST_W-1:0] est_az;
        logic signed [EST_W-1:0] est_mx;
        logic signed [EST_W-1:0] est_my;
        logic signed [EST_W-1:0] est_mz;
    } est_t;

endpackage

// ===== hw/rtl/skn_lane.sv =====
module skn_lane #(
    parameter int DATA_WIDTH = skn_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [DATA_WIDTH-1:0]       x_in,
    input  logic [skn_pkg::VAR_W-1:0]          p_in,
    input  logic [skn_pkg::VAR_W-1:0]          q,
    input  logic [skn_pkg::VAR_W-1:0]          r,
    input  logic signed [skn_pkg::MEAS_W-1:0]  z,
    output logic                               done,
    output logic signed [DATA_WIDTH-1:0]       x_out,
    output logic [skn_pkg::VAR_W-1:0]          p_out
);
    import skn_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int DW    = ((W > MEAS_W) ? W : MEAS_W) + 1;
    localparam int KW    = GAIN_FRAC + 1;
    localparam int PW    = VAR_W + 1;
    localparam int NW    = VAR_W + GAIN_FRAC + 1;
    localparam int A1W   = DW + KW;
    localparam int A2W   = VAR_W + KW;
    localparam int CNT_W = $clog2(KW);

    localparam logic [KW-1:0]   K_ONE = KW'(1) << GAIN_FRAC;
    localparam logic [A1W:0]    HALF1 = (A1W + 1)'(1) << (GAIN_FRAC - 1);
    localparam logic [A2W:0]    HALF2 = (A2W + 1)'(1) << (GAIN_FRAC - 1);
    localparam logic [DW+1:0]   XCAP  = (DW + 2)'(1) << (W - 1);

    typedef enum logic [7:0] {
        L_IDLE = 8'b00000001,
        L_DEN  = 8'b00000010,
        L_DIVI = 8'b00000100,
        L_DIV  = 8'b00001000,
        L_MULI = 8'b00010000,
        L_MUL  = 8'b00100000,
        L_RND  = 8'b01000000,
        L_FIN  = 8'b10000000
    } lane_state_t;

    lane_state_t                state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [VAR_W-1:0]           p_reg;
    logic signed [W-1:0]        x_reg;
    logic signed [MEAS_W-1:0]   z_reg;
    logic [PW-1:0]              den_reg;
    logic [PW-1:0]              rem_reg;
    logic [KW-1:0]              nlow_reg;
    logic [KW-1:0]              k_reg;
    logic signed [DW-1:0]       diff_reg;
    logic [DW-1:0]              a1_reg;
    logic [KW-1:0]              b1_reg;
    logic [KW-1:0]              b2_reg;
    logic [A1W-1:0]             acc1_reg;
    logic [A2W-1:0]             acc2_reg;
    logic signed [W:0]          rs_reg;
    logic                       done_reg;
    logic signed [W-1:0]        x_out_reg;
    logic [VAR_W-1:0]           p_out_reg;

    logic [VAR_W:0]             p_sum;
    logic [VAR_W-1:0]           p_sat;
    logic [PW-1:0]              den_sum;
    logic [NW-1:0]              num;
    logic [PW:0]                rem_sh;
    logic                       div_ge;
    logic [PW:0]                rem_dif;
    logic signed [DW-1:0]       diff_val;
    logic [DW-1:0]              diff_mag;
    logic [KW-1:0]              k_use;
    logic [A1W:0]               rnd1;
    logic [DW+1:0]              m1;
    logic [DW+1:0]              m1_cap;
    logic signed [W:0]          rs_val;
    logic signed [W+1:0]        xsum;
    logic signed [W-1:0]        xsat;
    logic [A2W:0]               rnd2;

    always_comb
    begin
        p_sum    = {1'b0, p_in} + {1'b0, q};
        p_sat    = p_sum[VAR_W] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];
        den_sum  = {1'b0, p_reg} + {1'b0, r};
        num      = (NW'(p_reg) << GAIN_FRAC) + NW'(den_reg >> 1);
        rem_sh   = {rem_reg, nlow_reg[KW-1]};
        div_ge   = rem_sh >= {1'b0, den_reg};
        rem_dif  = rem_sh - {1'b0, den_reg};
        diff_val = DW'(z_reg) - DW'(x_reg);
        diff_mag = diff_reg[DW-1] ? DW'(-diff_reg) : DW'(diff_reg);
        // A zero denominator means zero variance and zero noise: no update.
        k_use    = (den_reg == '0) ? '0 : k_reg;
        rnd1     = {1'b0, acc1_reg} + HALF1;
        m1       = rnd1[A1W:GAIN_FRAC];
        m1_cap   = (m1 > XCAP) ? XCAP : m1;
        if (diff_reg[DW-1])
        begin
            rs_val = -$signed({1'b0, m1_cap[W-1:0]});
        end
        else if (m1_cap == XCAP)
        begin
            rs_val = $signed({1'b0, m1_cap[W-1:0] - 1'b1});
        end
        else
        begin
            rs_val = $signed({1'b0, m1_cap[W-1:0]});
        end
        xsum = (W + 2)'(x_reg) + (W + 2)'(rs_reg);
        if (xsum[W+1] && !(&xsum[W:W-1]))
        begin
            xsat = $signed({1'b1, {(W-1){1'b0}}});
        end
        else if (!xsum[W+1] && (|xsum[W:W-1]))
        begin
            xsat = $signed({1'b0, {(W-1){1'b1}}});
        end
        else
        begin
            xsat = xsum[W-1:0];
        end
        rnd2 = {1'b0, acc2_reg} + HALF2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == L_FIN);
            unique case (state_reg)
                L_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= L_DEN;
                    end
                end
                L_DEN:
                begin
                    state_reg <= L_DIVI;
                end
                L_DIVI:
                begin
                    cnt_reg   <= CNT_W'(KW - 1);
                    state_reg <= L_DIV;
                end
                L_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= L_MULI;
                    end
                end
                L_MULI:
                begin
                    cnt_reg   <= CNT_W'(KW - 1);
                    state_reg <= L_MUL;
                end
                L_MUL:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= L_RND;
                    end
                end
                L_RND:
                begin
                    state_reg <= L_FIN;
                end
                L_FIN:
                begin
                    state_reg <= L_IDLE;
                end
                default:
                begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                p_reg <= p_sat;
                x_reg <= x_in;
                z_reg <= z;
            end
            L_DEN:
            begin
                den_reg  <= den_sum;
                diff_reg <= diff_val;
            end
            L_DIVI:
            begin
                rem_reg  <= PW'(num[NW-1:KW]);
                nlow_reg <= num[KW-1:0];
                k_reg    <= '0;
            end
            L_DIV:
            begin
                rem_reg  <= div_ge ? rem_dif[PW-1:0] : rem_sh[PW-1:0];
                k_reg    <= {k_reg[KW-2:0], div_ge};
                nlow_reg <= nlow_reg << 1;
            end
            L_MULI:
            begin
                a1_reg   <= diff_mag;
                b1_reg   <= k_use;
                b2_reg   <= K_ONE - k_use;
                acc1_reg <= '0;
                acc2_reg <= '0;
            end
            L_MUL:
            begin
                acc1_reg <= (acc1_reg << 1) + (b1_reg[KW-1] ? A1W'(a1_reg) : '0);
                acc2_reg <= (acc2_reg << 1) + (b2_reg[KW-1] ? A2W'(p_reg) : '0);
                b1_reg   <= b1_reg << 1;
                b2_reg   <= b2_reg << 1;
            end
            L_RND:
            begin
                rs_reg    <= rs_val;
                p_out_reg <= rnd2[GAIN_FRAC +: VAR_W];
            end
            L_FIN:
            begin
                x_out_reg <= xsat;
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign x_out = x_out_reg;
    assign p_out = p_out_reg;

endmodule

// ===== hw/rtl/skn_norm.sv =====
module skn_norm #(
    parameter int DATA_WIDTH = skn_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DATA_WIDTH-1:0]  x_in [3],
    input  logic [skn_pkg::REF_W-1:0]     ref_mag,
    input  logic [skn_pkg::LAM_W-1:0]     lam,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  x_out [3]
);
    import skn_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int SW    = 2 * W;
    localparam int RW    = W + 3;
    localparam int NBW   = ((W > REF_W + NORM_FRAC) ? W : (REF_W + NORM_FRAC)) + 1;
    localparam int FW    = NBW + LAM_W + 1;
    localparam int SCW   = W + FW;
    localparam int MW    = SCW + 1 - SCALE_FRAC;
    localparam int CNT_W = $clog2(NBW);

    localparam logic [SCW:0]  HALF = (SCW + 1)'(1) << (SCALE_FRAC - 1);
    localparam logic [MW-1:0] XCAP = MW'(1) << (W - 1);

    typedef enum logic [9:0] {
        N_IDLE  = 10'b0000000001,
        N_SQ    = 10'b0000000010,
        N_SUM   = 10'b0000000100,
        N_SQRT  = 10'b0000001000,
        N_NUM   = 10'b0000010000,
        N_DIV   = 10'b0000100000,
        N_MULF  = 10'b0001000000,
        N_FADD  = 10'b0010000000,
        N_SCALE = 10'b0100000000,
        N_RND   = 10'b1000000000
    } norm_state_t;

    norm_state_t         state_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [W-1:0]        mag_reg [3];
    logic                neg_reg [3];
    logic [W-1:0]        sh_reg [3];
    logic [SW-1:0]       sq_reg [3];
    logic [SW-1:0]       s_reg;
    logic [RW-1:0]       srem_reg;
    logic [W-1:0]        root_reg;
    logic [NBW-1:0]      num_reg;
    logic [W-1:0]        drem_reg;
    logic [NBW-1:0]      ratio_reg;
    logic [LAM_W-1:0]    lsh_reg;
    logic [FW-1:0]       facc_reg;
    logic [FW-1:0]       f_reg;
    logic [SCW-1:0]      sc_reg [3];
    logic signed [W-1:0] x_out_reg [3];
    logic                done_reg;

    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;
    logic                sq_ge;
    logic [W-1:0]        root_fix;
    logic [W:0]          dsh;
    logic                div_ge;
    logic [SCW:0]        rnd [3];
    logic [MW-1:0]       m_raw [3];
    logic [MW-1:0]       m_cap [3];
    logic signed [W-1:0] res [3];

    always_comb
    begin
        rem_sh   = {srem_reg[RW-3:0], s_reg[SW-1:SW-2]};
        trial    = RW'({root_reg, 2'b01});
        sq_ge    = rem_sh >= trial;
        // The magnitude is floored at one LSB so a zero vector stays zero.
        root_fix = (root_reg == '0) ? W'(1) : root_reg;
        dsh      = {drem_reg, num_reg[NBW-1]};
        div_ge   = dsh >= {1'b0, root_reg};
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]   = {1'b0, sc_reg[i]} + HALF;
            m_raw[i] = rnd[i][SCW:SCALE_FRAC];
            m_cap[i] = (m_raw[i] > XCAP) ? XCAP : m_raw[i];
            if (neg_reg[i])
            begin
                res[i] = W'(-$signed({1'b0, m_cap[i][W-1:0]}));
            end
            else if (m_cap[i] == XCAP)
            begin
                res[i] = $signed(m_cap[i][W-1:0] - 1'b1);
            end
            else
            begin
                res[i] = $signed(m_cap[i][W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == N_RND);
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        cnt_reg   <= CNT_W'(W - 1);
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_SUM;
                    end
                end
                N_SUM:
                begin
                    cnt_reg   <= CNT_W'(W - 1);
                    state_reg <= N_SQRT;
                end
                N_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_NUM;
                    end
                end
                N_NUM:
                begin
                    cnt_reg   <= CNT_W'(NBW - 1);
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        cnt_reg   <= CNT_W'(LAM_W - 1);
                        state_reg <= N_MULF;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                N_MULF:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_FADD;
                    end
                end
                N_FADD:
                begin
                    cnt_reg   <= CNT_W'(W - 1);
                    state_reg <= N_SCALE;
                end
                N_SCALE:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= N_RND;
                    end
                end
                N_RND:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= x_in[i][W-1];
                    mag_reg[i] <= x_in[i][W-1] ? W'(-x_in[i]) : W'(x_in[i]);
                    sh_reg[i]  <= x_in[i][W-1] ? W'(-x_in[i]) : W'(x_in[i]);
                    sq_reg[i]  <= '0;
                end
            end
            N_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= (sq_reg[i] << 1) + (sh_reg[i][W-1] ? SW'(mag_reg[i]) : '0);
                    sh_reg[i] <= sh_reg[i] << 1;
                end
            end
            N_SUM:
            begin
                s_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
                srem_reg <= '0;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                srem_reg <= sq_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[W-2:0], sq_ge};
                s_reg    <= s_reg << 2;
            end
            N_NUM:
            begin
                root_reg <= root_fix;
                num_reg  <= (NBW'(ref_mag) << NORM_FRAC) + NBW'(root_fix >> 1);
                drem_reg <= '0;
                ratio_reg <= '0;
            end
            N_DIV:
            begin
                drem_reg  <= div_ge ? W'(dsh - {1'b0, root_reg}) : W'(dsh);
                ratio_reg <= {ratio_reg[NBW-2:0], div_ge};
                num_reg   <= num_reg << 1;
                lsh_reg   <= lam;
                facc_reg  <= '0;
            end
            N_MULF:
            begin
                facc_reg <= (facc_reg << 1) + (lsh_reg[LAM_W-1] ? FW'(ratio_reg) : '0);
                lsh_reg  <= lsh_reg << 1;
            end
            N_FADD:
            begin
                f_reg <= facc_reg + (FW'(LAM_ONE - lam) << NORM_FRAC);
                for (int i = 0; i < 3; i++)
                begin
                    sh_reg[i] <= mag_reg[i];
                    sc_reg[i] <= '0;
                end
            end
            N_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sc_reg[i] <= (sc_reg[i] << 1) + (sh_reg[i][W-1] ? SCW'(f_reg) : '0);
                    sh_reg[i] <= sh_reg[i] << 1;
                end
            end
            N_RND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_out_reg[i] <= res[i];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = done_reg;
    assign x_out = x_out_reg;

endmodule

// ===== hw/rtl/six_axis_scalar_kalman_norm_top.sv =====
// Six-axis scalar Kalman filter with a magnitude constraint on each vector.
// The input channel (in_valid, in_ready, in_data) carries one word holding a
// sample of three accelerometer and three magnetometer axes in signed Q16.16.
// The output channel (out_valid, out_ready, out_data) returns one word per
// input word with the six filtered estimates, saturated to signed Q16.16.
// The six axis lanes each run a bit-serial gain division and two shift-add
// multiplies; the two norm units then run a bit-serial square sum, square
// root, ratio division and scaling. One word is in flight at a time; the
// next word can be accepted in the same cycle that the result appears.
// The configuration port writes one register per cycle with cfg_we; any
// write to a known index reloads all estimates to zero and all variances to
// p_initial. Writes are expected only while the block is idle.
// Reset loads the register defaults and that same initial state.
// When the receiver stalls, the finished word waits in the output register,
// the next input word is still accepted, and its result is held back until
// the output register is free.
module six_axis_scalar_kalman_norm_top #(
    parameter int DATA_WIDTH = skn_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  skn_pkg::meas_t                    in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output skn_pkg::est_t                     out_data,
    input  logic                              cfg_we,
    input  logic [skn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [skn_pkg::CFG_W-1:0]         cfg_data
);
    import skn_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int EXT_W = ((W > EST_W) ? W : EST_W) + 1;

    localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'(32'sh7FFFFFFF);
    localparam logic signed [EXT_W-1:0] OUT_MIN = EXT_W'($signed(32'h80000000));

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LANE = 4'b0010,
        S_NORM = 4'b0100,
        S_HOLD = 4'b1000
    } top_state_t;

    // Saturates an internal estimate to the 32-bit output format.
    function automatic logic signed [EST_W-1:0] sat_out(input logic signed [W-1:0] v);
        logic signed [EXT_W-1:0] ve;
        ve = EXT_W'(v);
        if (ve > OUT_MAX)
        begin
            return OUT_MAX[EST_W-1:0];
        end
        else if (ve < OUT_MIN)
        begin
            return OUT_MIN[EST_W-1:0];
        end
        return ve[EST_W-1:0];
    endfunction

    top_state_t            state_reg;
    logic [VAR_W-1:0]      q_accel_reg;
    logic [VAR_W-1:0]      r_accel_reg;
    logic [VAR_W-1:0]      q_magnet_reg;
    logic [VAR_W-1:0]      r_magnet_reg;
    logic [VAR_W-1:0]      p_initial_reg;
    logic [LAM_W-1:0]      norm_weight_reg;
    logic [REF_W-1:0]      gravity_ref_reg;
    logic [REF_W-1:0]      field_ref_reg;
    meas_t                 meas_reg;
    logic signed [W-1:0]   x_reg [NUM_AXES];
    logic [VAR_W-1:0]      p_reg [NUM_AXES];
    logic                  lane_start_reg;
    logic                  norm_start_reg;
    est_t                  out_reg;
    logic                  out_valid_reg;

    logic                  cfg_hit;
    logic [VAR_W-1:0]      p_init_next;
    logic [LAM_W-1:0]      lam_eff;
    logic                  commit;
    logic signed [MEAS_W-1:0] meas_z [NUM_AXES];
    logic [NUM_AXES-1:0]   lane_done;
    logic signed [W-1:0]   lane_x [NUM_AXES];
    logic [VAR_W-1:0]      lane_p [NUM_AXES];
    logic signed [W-1:0]   acc_x [3];
    logic signed [W-1:0]   mag_x [3];
    logic signed [W-1:0]   acc_n [3];
    logic signed [W-1:0]   mag_n [3];
    logic                  acc_done;
    logic                  mag_done;

    assign cfg_hit     = cfg_we && (cfg_index <= REG_FIELD_REF);
    assign p_init_next = (cfg_index == REG_P_INITIAL) ? cfg_data[VAR_W-1:0] : p_initial_reg;
    // A weight above one acts as one.
    assign lam_eff     = (norm_weight_reg > LAM_ONE) ? LAM_ONE : norm_weight_reg;
    assign in_ready    = (state_reg == S_IDLE);
    assign commit      = (state_reg == S_HOLD) && (!out_valid_reg || out_ready);

    assign meas_z[0] = meas_reg.meas_ax;
    assign meas_z[1] = meas_reg.meas_ay;
    assign meas_z[2] = meas_reg.meas_az;
    assign meas_z[3] = meas_reg.meas_mx;
    assign meas_z[4] = meas_reg.meas_my;
    assign meas_z[5] = meas_reg.meas_mz;

    // One Kalman lane per axis; the first three use the accelerometer noise
    // terms and the last three the magnetometer noise terms.
    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_lane
        skn_lane #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .start (lane_start_reg),
            .x_in  (x_reg[g]),
            .p_in  (p_reg[g]),
            .q     ((g < 3) ? q_accel_reg : q_magnet_reg),
            .r     ((g < 3) ? r_accel_reg : r_magnet_reg),
            .z     (meas_z[g]),
            .done  (lane_done[g]),
            .x_out (lane_x[g]),
            .p_out (lane_p[g])
        );
    end

    assign acc_x[0] = lane_x[0];
    assign acc_x[1] = lane_x[1];
    assign acc_x[2] = lane_x[2];
    assign mag_x[0] = lane_x[3];
    assign mag_x[1] = lane_x[4];
    assign mag_x[2] = lane_x[5];

    // The merge stage: each vector is pulled toward its reference magnitude.
    skn_norm #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_norm_accel (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (norm_start_reg),
        .x_in    (acc_x),
        .ref_mag (gravity_ref_reg),
        .lam     (lam_eff),
        .done    (acc_done),
        .x_out   (acc_n)
    );

    skn_norm #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_norm_magnet (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (norm_start_reg),
        .x_in    (mag_x),
        .ref_mag (field_ref_reg),
        .lam     (lam_eff),
        .done    (mag_done),
        .x_out   (mag_n)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            q_accel_reg     <= RST_NOISE;
            r_accel_reg     <= RST_NOISE;
            q_magnet_reg    <= RST_NOISE;
            r_magnet_reg    <= RST_NOISE;
            p_initial_reg   <= RST_P_INITIAL;
            norm_weight_reg <= RST_WEIGHT;
            gravity_ref_reg <= RST_REF;
            field_ref_reg   <= RST_REF;
            lane_start_reg  <= 1'b0;
            norm_start_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                x_reg[i] <= '0;
                p_reg[i] <= RST_P_INITIAL;
            end
        end
        else
        begin
            lane_start_reg <= (state_reg == S_IDLE) && in_valid;
            norm_start_reg <= (state_reg == S_LANE) && (&lane_done);

            // A finished word replaces the one leaving in the same cycle.
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LANE;
                    end
                end
                S_LANE:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if (acc_done && mag_done)
                    begin
                        state_reg <= S_HOLD;
                    end
                end
                S_HOLD:
                begin
                    if (commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (commit && !cfg_hit)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    x_reg[i]     <= acc_n[i];
                    x_reg[i + 3] <= mag_n[i];
                end
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    p_reg[i] <= lane_p[i];
                end
            end

            // A register write stores the value and restarts the filter state.
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    REG_Q_ACCEL:     q_accel_reg     <= cfg_data[VAR_W-1:0];
                    REG_R_ACCEL:     r_accel_reg     <= cfg_data[VAR_W-1:0];
                    REG_Q_MAGNET:    q_magnet_reg    <= cfg_data[VAR_W-1:0];
                    REG_R_MAGNET:    r_magnet_reg    <= cfg_data[VAR_W-1:0];
                    REG_P_INITIAL:   p_initial_reg   <= cfg_data[VAR_W-1:0];
                    REG_NORM_WEIGHT: norm_weight_reg <= cfg_data[LAM_W-1:0];
                    REG_GRAVITY_REF: gravity_ref_reg <= cfg_data[REF_W-1:0];
                    REG_FIELD_REF:   field_ref_reg   <= cfg_data[REF_W-1:0];
                    default:
                    begin
                    end
                endcase
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    x_reg[i] <= '0;
                    p_reg[i] <= p_init_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= in_data;
        end
        if (commit)
        begin
            out_reg.est_ax <= sat_out(acc_n[0]);
            out_reg.est_ay <= sat_out(acc_n[1]);
            out_reg.est_az <= sat_out(acc_n[2]);
            out_reg.est_mx <= sat_out(mag_n[0]);
            out_reg.est_my <= sat_out(mag_n[1]);
            out_reg.est_mz <= sat_out(mag_n[2]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // All lanes start together and take the same number of cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (|lane_done) |-> (&lane_done))
        else $error("axis lanes finished out of step");

    // The two norm units run in lockstep and only inside the norm phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_done || mag_done) |-> (acc_done && mag_done && state_reg == S_NORM))
        else $error("norm units finished outside the norm phase");

    // An accepted word launches the lanes on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_LANE && lane_start_reg))
        else $error("accepted word did not start the lanes");

    // A register write leaves the filter in its initial state.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (x_reg[0] == '0 && p_reg[5] == p_initial_reg))
        else $error("register write did not reinitialize the state");

endmodule

// ===== test/six_axis_scalar_kalman_norm_top_tb.sv =====
`timescale 1ns / 1ps

module six_axis_scalar_kalman_norm_top_tb;
    import skn_pkg::*;

    localparam int DW = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    meas_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    est_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    six_axis_scalar_kalman_norm_top #(.DATA_WIDTH(DW)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Filter model: its own register copy and per-axis state.
    logic [63:0] flt_reg [8];
    logic signed [63:0] flt_est [6];
    logic [31:0] flt_var [6];

    meas_t send_q[$];
    est_t filtered_q[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int cfg_writes = 0;
    int send_idle = 0;
    int recv_stall = 0;

    function automatic logic signed [63:0] sat_w(logic signed [63:0] v, int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Signed value times unsigned factor over 2^sh; magnitude rounded half up.
    function automatic logic signed [63:0] scale_by(logic signed [63:0] v,
                                                   logic [63:0] f, int sh);
        logic [63:0] mag;
        logic [127:0] prod;
        logic [127:0] cap;
        mag = v < 0 ? -v : v;
        prod = (128'(mag) * 128'(f) + (128'd1 << (sh - 1))) >> sh;
        cap = 128'd1 << (DW - 1);
        if (prod > cap) prod = cap;
        if (v < 0) return -$signed(64'(prod));
        if (prod > cap - 1) prod = cap - 1;
        return $signed(64'(prod));
    endfunction

    task automatic reload_state();
        for (int i = 0; i < 6; i++)
        begin
            flt_est[i] = 0;
            flt_var[i] = flt_reg[REG_P_INITIAL][31:0];
        end
    endtask

    function automatic void constrain_vector(int base, logic [63:0] ref_mag,
                                             logic [63:0] lam);
        logic [127:0] sum;
        logic [127:0] cand;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] ratio;
        logic [63:0] f;
        sum = 0;
        root = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag = flt_est[base + i] < 0 ? -flt_est[base + i] : flt_est[base + i];
            sum += 128'(mag) * 128'(mag);
        end
        for (int b = 47; b >= 0; b--)
        begin
            cand = 128'(root | (64'd1 << b));
            if (cand * cand <= sum) root = root | (64'd1 << b);
        end
        if (root == 0) root = 1;
        ratio = ((ref_mag << 16) + root / 2) / root;
        f = ((64'd65536 - lam) << 16) + lam * ratio;
        for (int i = 0; i < 3; i++)
            flt_est[base + i] = scale_by(flt_est[base + i], f, 32);
    endfunction

    function automatic est_t filter_sample(meas_t m);
        logic signed [31:0] z [6];
        logic [63:0] lam;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] den;
        logic [63:0] k;
        logic signed [63:0] diff;
        est_t o;
        z = '{m.meas_ax, m.meas_ay, m.meas_az, m.meas_mx, m.meas_my, m.meas_mz};
        lam = flt_reg[REG_NORM_WEIGHT] > 65536 ? 64'd65536 : flt_reg[REG_NORM_WEIGHT];
        for (int i = 0; i < 6; i++)
        begin
            q = i < 3 ? flt_reg[REG_Q_ACCEL] : flt_reg[REG_Q_MAGNET];
            r = i < 3 ? flt_reg[REG_R_ACCEL] : flt_reg[REG_R_MAGNET];
            p = 64'(flt_var[i]) + q;
            if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
            den = p + r;
            k = den == 0 ? 64'd0 : ((p << 24) + den / 2) / den;
            diff = 64'(z[i]) - flt_est[i];
            flt_est[i] = sat_w(flt_est[i] + scale_by(diff, k, 24), DW);
            flt_var[i] = 32'((((64'd1 << 24) - k) * p + (64'd1 << 23)) >> 24);
        end
        constrain_vector(0, flt_reg[REG_GRAVITY_REF], lam);
        constrain_vector(3, flt_reg[REG_FIELD_REF], lam);
        o.est_ax = 32'(sat_w(flt_est[0], 32));
        o.est_ay = 32'(sat_w(flt_est[1], 32));
        o.est_az = 32'(sat_w(flt_est[2], 32));
        o.est_mx = 32'(sat_w(flt_est[3], 32));
        o.est_my = 32'(sat_w(flt_est[4], 32));
        o.est_mz = 32'(sat_w(flt_est[5], 32));
        return o;
    endfunction

    // Driver: presents queued words, honoring random sender gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                filtered_q.push_back(filter_sample(in_data));
                words_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    in_data <= send_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each returned word against the oldest prediction.
    always @(posedge clk)
    begin
        est_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                words_out++;
                if (filtered_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, out_data);
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (want !== out_data)
                    begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic logic [31:0] rand_meas();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(262144)) - 131072);
            3: return 32'($signed($urandom_range(1310720)) - 655360);
            default: return $urandom;
        endcase
    endfunction

    function automatic meas_t rand_sample();
        meas_t m;
        m.meas_ax = rand_meas();
        m.meas_ay = rand_meas();
        m.meas_az = rand_meas();
        m.meas_mx = rand_meas();
        m.meas_my = rand_meas();
        m.meas_mz = rand_meas();
        return m;
    endfunction

    function automatic meas_t const_sample(logic [31:0] v);
        return '{v, v, v, v, v, v};
    endfunction

    // Waits until every queued word has been sent and answered, then lets the
    // pipeline drain before touching the configuration.
    task automatic drain();
        while (send_q.size() > 0 || in_valid || filtered_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < 8)
        begin
            flt_reg[idx] = val & (idx == REG_NORM_WEIGHT ? 64'h1FFFF :
                (idx >= REG_GRAVITY_REF ? 64'h7FFF_FFFF : 64'hFFFF_FFFF));
            reload_state();
        end
        cfg_writes++;
    endtask

    task automatic rand_config();
        write_reg(REG_Q_ACCEL, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
        write_reg(REG_R_ACCEL, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
        write_reg(REG_Q_MAGNET, $urandom_range(3) == 0 ? $urandom : $urandom_range(200000));
        write_reg(REG_R_MAGNET, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000000));
        write_reg(REG_P_INITIAL, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 25));
        write_reg(REG_NORM_WEIGHT, $urandom_range(3) == 0 ? $urandom : $urandom_range(65536));
        write_reg(REG_GRAVITY_REF, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
        write_reg(REG_FIELD_REF, $urandom_range(3) == 0 ? $urandom : $urandom_range(1 << 20));
    endtask

    initial
    begin
        flt_reg = '{64'd16777, 64'd16777, 64'd16777, 64'd16777, 64'd16777216,
                    64'd0, 64'd65536, 64'd65536};
        reload_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset defaults: extremes, zero vector, and signs.
        send_q.push_back(const_sample(32'h0));
        send_q.push_back(const_sample(32'h7FFF_FFFF));
        send_q.push_back(const_sample(32'h8000_0000));
        send_q.push_back(const_sample(32'hFFFF_FFFF));
        send_q.push_back('{32'h10000, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h0});
        drain();

        // Zero variance with zero noise keeps estimate and variance.
        write_reg(REG_Q_ACCEL, 0);
        write_reg(REG_R_ACCEL, 0);
        write_reg(REG_Q_MAGNET, 0);
        write_reg(REG_R_MAGNET, 0);
        write_reg(REG_P_INITIAL, 0);
        send_q.push_back(const_sample(32'h12345));
        send_q.push_back(const_sample(32'h8000_0000));
        drain();

        // Largest noise and variance, a weight above one, and full references.
        write_reg(REG_Q_ACCEL, 32'hFFFF_FFFF);
        write_reg(REG_R_ACCEL, 32'hFFFF_FFFF);
        write_reg(REG_Q_MAGNET, 32'hFFFF_FFFF);
        write_reg(REG_R_MAGNET, 32'hFFFF_FFFF);
        write_reg(REG_P_INITIAL, 32'hFFFF_FFFF);
        write_reg(REG_NORM_WEIGHT, 32'hFFFF_FFFF);
        write_reg(REG_GRAVITY_REF, 32'hFFFF_FFFF);
        write_reg(REG_FIELD_REF, 32'h7FFF_FFFF);
        write_reg(4'd12, 32'h5A5A_5A5A);
        for (int i = 0; i < 6; i++) send_q.push_back(rand_sample());
        send_q.push_back(const_sample(32'h0));
        drain();

        // Exact weight of one, zero references.
        write_reg(REG_NORM_WEIGHT, 32'h10000);
        write_reg(REG_GRAVITY_REF, 0);
        write_reg(REG_FIELD_REF, 0);
        send_q.push_back(const_sample(32'h7FFF_FFFF));
        send_q.push_back(rand_sample());
        drain();

        // Random phases with different idling on each side.
        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 53; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 53; end
                default: begin send_idle = 31; recv_stall = 31; end
            endcase
            rand_config();
            for (int n = 0; n < 105; n++) send_q.push_back(rand_sample());
            drain();
        end

        $display("Covered %0d sample words, %0d returned, %0d register writes.",
                 words_in, words_out, cfg_writes);
        $display("Configurations included zero and full noise and weights over one.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Slowest run: 1696 words, with receiver stalls lengthening it.
    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
